>>> rtl/fgb_pkg.sv
`default_nettype none

package fgb_pkg;

    // default geometry
    localparam int GLYPH_W_DEF     = 6;
    localparam int GLYPH_H_DEF     = 8;
    localparam int SHEET_MAX_W_DEF = 128;
    localparam int SHEET_MAX_H_DEF = 128;

    // glyph cells per sheet row, code splits into cell column and cell row
    localparam int CELLS_PER_ROW = 16;
    localparam int CELL_BITS     = 4;

    // item field widths
    localparam int OP_W     = 1;
    localparam int LOAD_X_W = 7;
    localparam int LOAD_Y_W = 7;
    localparam int COLOUR_W = 8;
    localparam int CODE_W   = 8;
    localparam int POS_W    = 6;
    localparam int ORIGIN_W = 10;
    localparam int SCREEN_W = 11;

    // op codes
    localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
    localparam logic [OP_W-1:0] OP_DRAW = 1'b1;

    // configuration registers
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SHEET_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHEET_HEIGHT = 2'd1;
    localparam logic [CFG_DATA_W-1:0] SHEET_WIDTH_RST  = 8'd96;
    localparam logic [CFG_DATA_W-1:0] SHEET_HEIGHT_RST = 8'd128;

    // what travels alongside a pending sheet read
    typedef struct packed {
        logic [SCREEN_W-1:0] screen_x;
        logic [SCREEN_W-1:0] screen_y;
        logic                write_enable;
        logic                last_pixel;
    } pix_meta_t;

endpackage

`default_nettype wire

>>> rtl/fgb_if.sv
`default_nettype none

interface fgb_cmd_if
    import fgb_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [LOAD_X_W-1:0] load_x;
    logic [LOAD_Y_W-1:0] load_y;
    logic [COLOUR_W-1:0] load_colour;
    logic [CODE_W-1:0]   char_code;
    logic [POS_W-1:0]    char_pos;
    logic [ORIGIN_W-1:0] origin_x;
    logic [ORIGIN_W-1:0] origin_y;

    modport source (
        output valid, op, load_x, load_y, load_colour, char_code, char_pos,
               origin_x, origin_y,
        input  ready
    );
    modport sink (
        input  valid, op, load_x, load_y, load_colour, char_code, char_pos,
               origin_x, origin_y,
        output ready
    );
endinterface

interface fgb_pix_if
    import fgb_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SCREEN_W-1:0] screen_x;
    logic [SCREEN_W-1:0] screen_y;
    logic [COLOUR_W-1:0] colour;
    logic                write_enable;
    logic                last_pixel;

    modport source (
        output valid, screen_x, screen_y, colour, write_enable, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, screen_x, screen_y, colour, write_enable, last_pixel,
        output ready
    );
endinterface

interface fgb_cfg_if
    import fgb_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/fgb_font_mem.sv
`default_nettype none

module fgb_font_mem
    import fgb_pkg::*;
#(
    parameter int DEPTH  = SHEET_MAX_W_DEF * SHEET_MAX_H_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                clk,
    input  wire logic                wr_en,
    input  wire logic [ADDR_W-1:0]   wr_addr,
    input  wire logic [COLOUR_W-1:0] wr_data,
    input  wire logic                rd_en,
    input  wire logic [ADDR_W-1:0]   rd_addr,
    output logic      [COLOUR_W-1:0] rd_data
);

    logic [COLOUR_W-1:0] pix_mem [DEPTH];
    logic [COLOUR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pix_mem[wr_addr] <= wr_data;
        end
    end

    // read data only moves on a read, so it holds while the consumer stalls
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= pix_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/fgb_seq.sv
`default_nettype none

module fgb_seq
    import fgb_pkg::*;
#(
    parameter int GLYPH_W     = GLYPH_W_DEF,
    parameter int GLYPH_H     = GLYPH_H_DEF,
    parameter int SHEET_MAX_W = SHEET_MAX_W_DEF,
    parameter int SHEET_MAX_H = SHEET_MAX_H_DEF,
    parameter int ADDR_W      = $clog2(SHEET_MAX_W * SHEET_MAX_H)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [CODE_W-1:0]     char_code,
    input  wire logic [POS_W-1:0]      char_pos,
    input  wire logic [ORIGIN_W-1:0]   origin_x,
    input  wire logic [ORIGIN_W-1:0]   origin_y,
    input  wire logic [CFG_DATA_W-1:0] sheet_width,
    input  wire logic [CFG_DATA_W-1:0] sheet_height,
    input  wire logic                  advance,
    output logic                       busy,
    output logic                       fire,
    output logic [ADDR_W-1:0]          rd_addr,
    output pix_meta_t                  meta
);

    localparam int SX_W = $clog2(CELLS_PER_ROW * GLYPH_W);
    localparam int SY_W = $clog2(CELLS_PER_ROW * GLYPH_H);
    localparam int CW   = (GLYPH_W > 1) ? $clog2(GLYPH_W) : 1;
    localparam int RW   = (GLYPH_H > 1) ? $clog2(GLYPH_H) : 1;

    logic                busy_reg, busy_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [RW-1:0]       row_reg, row_next;
    logic [SX_W-1:0]     sx0_reg, sx0_next, sx_reg, sx_next;
    logic [SY_W-1:0]     sy_reg, sy_next;
    logic [SCREEN_W-1:0] dx0_reg, dx0_next, dx_reg, dx_next, dy_reg, dy_next;
    logic                row_end, glyph_end, x_in, y_in;

    assign row_end   = (col_reg == CW'(GLYPH_W - 1));
    assign glyph_end = row_end && (row_reg == RW'(GLYPH_H - 1));
    assign fire      = busy_reg && advance;
    assign busy      = busy_reg;

    // source pixel must sit inside both the configured and the stored sheet
    assign x_in = (32'(sx_reg) < 32'(sheet_width)) && (32'(sx_reg) < SHEET_MAX_W);
    assign y_in = (32'(sy_reg) < 32'(sheet_height)) && (32'(sy_reg) < SHEET_MAX_H);

    assign rd_addr = ADDR_W'(32'(sy_reg) * SHEET_MAX_W + 32'(sx_reg));

    always_comb
    begin
        meta.screen_x     = dx_reg;
        meta.screen_y     = dy_reg;
        meta.write_enable = x_in && y_in;
        meta.last_pixel   = glyph_end;
    end

    always_comb
    begin
        busy_next = busy_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        sx0_next  = sx0_reg;
        sx_next   = sx_reg;
        sy_next   = sy_reg;
        dx0_next  = dx0_reg;
        dx_next   = dx_reg;
        dy_next   = dy_reg;
        if (start)
        begin
            busy_next = 1'b1;
            col_next  = '0;
            row_next  = '0;
            sx0_next  = SX_W'(32'(char_code[CELL_BITS-1:0]) * GLYPH_W);
            sx_next   = sx0_next;
            sy_next   = SY_W'(32'(char_code[CODE_W-1:CELL_BITS]) * GLYPH_H);
            dx0_next  = SCREEN_W'(32'(origin_x) + 32'(char_pos) * GLYPH_W);
            dx_next   = dx0_next;
            dy_next   = SCREEN_W'(origin_y);
        end
        else if (fire)
        begin
            if (row_end)
            begin
                // wrap to the next glyph row
                col_next = '0;
                row_next = row_reg + 1'b1;
                sx_next  = sx0_reg;
                sy_next  = sy_reg + 1'b1;
                dx_next  = dx0_reg;
                dy_next  = dy_reg + 1'b1;
                if (glyph_end)
                begin
                    busy_next = 1'b0;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
                sx_next  = sx_reg + 1'b1;
                dx_next  = dx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sx0_reg <= sx0_next;
        sx_reg  <= sx_next;
        sy_reg  <= sy_next;
        dx0_reg <= dx0_next;
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
    end

endmodule

`default_nettype wire

>>> rtl/font_glyph_blitter.sv
// channel | dir | handshake   | carries
// cmd     | in  | valid/ready | op, load pixel or draw character fields
// pix     | out | valid/ready | screen_x, screen_y, colour, write_enable, last_pixel
// cfg     | in  | valid/ready | index, data (sheet_width, sheet_height)
//
// a load item writes one sheet pixel, if it lies inside the stored sheet; it gives no output
// a draw item makes GLYPH_W * GLYPH_H sheet reads (48 by default), one per cycle while the
// pix channel does not stall; each pixel passes the sequencer, read stage and output register
// reset clears control and sets the sheet registers; the sheet is not cleared
// a stalled pix channel holds the output register and the read stage, and the
// sequencer waits with them; cmd is taken only while no glyph is being walked
`default_nettype none

module font_glyph_blitter
    import fgb_pkg::*;
#(
    parameter int GLYPH_W     = GLYPH_W_DEF,
    parameter int GLYPH_H     = GLYPH_H_DEF,
    parameter int SHEET_MAX_W = SHEET_MAX_W_DEF,
    parameter int SHEET_MAX_H = SHEET_MAX_H_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fgb_cmd_if.sink    cmd,
    fgb_pix_if.source  pix,
    fgb_cfg_if.sink    cfg
);

    localparam int DEPTH  = SHEET_MAX_W * SHEET_MAX_H;
    localparam int ADDR_W = $clog2(DEPTH);

    // sheet size registers
    logic [CFG_DATA_W-1:0] sheet_width_reg, sheet_width_next;
    logic [CFG_DATA_W-1:0] sheet_height_reg, sheet_height_next;

    // command side
    logic              cmd_accept, draw_start, load_we;
    logic [ADDR_W-1:0] load_addr;

    // sequencer and memory
    logic                busy, fire, advance;
    logic [ADDR_W-1:0]   rd_addr;
    logic [COLOUR_W-1:0] rd_data;
    pix_meta_t           meta;

    // read stage: metadata of the pixel whose sheet read is in flight
    logic      s1_valid_reg, s1_valid_next, s1_move;
    pix_meta_t s1_meta_reg;

    // output register
    logic                out_valid_reg, out_valid_next;
    pix_meta_t           out_meta_reg;
    logic [COLOUR_W-1:0] out_colour_reg;

    // configuration writes, indexes beyond the list fall through
    assign cfg.ready = 1'b1;

    always_comb
    begin
        sheet_width_next  = sheet_width_reg;
        sheet_height_next = sheet_height_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_SHEET_WIDTH:  sheet_width_next  = cfg.data;
                REG_SHEET_HEIGHT: sheet_height_next = cfg.data;
                default:          ;
            endcase
        end
    end

    // commands are taken whenever the sequencer is idle
    assign cmd.ready  = !busy;
    assign cmd_accept = cmd.valid && cmd.ready;
    assign draw_start = cmd_accept && (cmd.op == OP_DRAW);

    // loads outside the stored sheet are dropped
    assign load_we = cmd_accept && (cmd.op == OP_LOAD)
                     && (32'(cmd.load_x) < SHEET_MAX_W)
                     && (32'(cmd.load_y) < SHEET_MAX_H);
    assign load_addr = ADDR_W'(32'(cmd.load_y) * SHEET_MAX_W + 32'(cmd.load_x));

    fgb_seq #(
        .GLYPH_W     (GLYPH_W),
        .GLYPH_H     (GLYPH_H),
        .SHEET_MAX_W (SHEET_MAX_W),
        .SHEET_MAX_H (SHEET_MAX_H),
        .ADDR_W      (ADDR_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (draw_start),
        .char_code    (cmd.char_code),
        .char_pos     (cmd.char_pos),
        .origin_x     (cmd.origin_x),
        .origin_y     (cmd.origin_y),
        .sheet_width  (sheet_width_reg),
        .sheet_height (sheet_height_reg),
        .advance      (advance),
        .busy         (busy),
        .fire         (fire),
        .rd_addr      (rd_addr),
        .meta         (meta)
    );

    fgb_font_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (load_we),
        .wr_addr (load_addr),
        .wr_data (cmd.load_colour),
        .rd_en   (fire),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // the read stage drains into the output register when that one is free
    // or emptied this cycle; a new read is issued only into an empty or draining stage
    assign s1_move = s1_valid_reg && (!out_valid_reg || pix.ready);
    assign advance = !s1_valid_reg || s1_move;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (pix.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sheet_width_reg  <= SHEET_WIDTH_RST;
            sheet_height_reg <= SHEET_HEIGHT_RST;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            sheet_width_reg  <= sheet_width_next;
            sheet_height_reg <= sheet_height_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_meta_reg <= meta;
        end
        if (s1_move)
        begin
            out_meta_reg <= s1_meta_reg;
            // off-sheet pixels read as colour zero
            out_colour_reg <= s1_meta_reg.write_enable ? rd_data : '0;
        end
    end

    assign pix.valid        = out_valid_reg;
    assign pix.screen_x     = out_meta_reg.screen_x;
    assign pix.screen_y     = out_meta_reg.screen_y;
    assign pix.colour       = out_colour_reg;
    assign pix.write_enable = out_meta_reg.write_enable;
    assign pix.last_pixel   = out_meta_reg.last_pixel;

    // sheet read data must survive a stalled read stage
    a_rd_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> $stable(rd_data))
        else $error("sheet read data moved under a stalled read stage");

    // a read is never issued into an occupied, non-draining read stage
    a_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |-> !fire)
        else $error("sheet read issued over a pending pixel");

    // loads only land while no glyph is being walked
    a_load_idle : assert property (@(posedge clk) disable iff (!rst_n)
        load_we |-> !busy)
        else $error("sheet load during a glyph walk");

    // masked pixels carry colour zero
    a_masked_colour : assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && !pix.write_enable) |-> (pix.colour == '0))
        else $error("masked pixel with non-zero colour");

endmodule

`default_nettype wire

>>> tb/sv/tb_font_glyph_blitter.sv
`default_nettype none

module tb_font_glyph_blitter;
    import fgb_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int MAX_PRINTS    = 40;
    localparam int POOL_SIZE     = 3;
    localparam int GLYPH_PIXELS  = GLYPH_W_DEF * GLYPH_H_DEF;

    // register indexes past the two real registers, written to show they are ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE0 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE1 = 2'd3;

    // one command item as it crosses the cmd channel
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [LOAD_X_W-1:0] load_x;
        logic [LOAD_Y_W-1:0] load_y;
        logic [COLOUR_W-1:0] load_colour;
        logic [CODE_W-1:0]   char_code;
        logic [POS_W-1:0]    char_pos;
        logic [ORIGIN_W-1:0] origin_x;
        logic [ORIGIN_W-1:0] origin_y;
    } cmd_item_t;

    // one pixel write as it leaves on the pix channel
    typedef struct packed {
        logic [SCREEN_W-1:0] screen_x;
        logic [SCREEN_W-1:0] screen_y;
        logic [COLOUR_W-1:0] colour;
        logic                write_enable;
        logic                last_pixel;
    } pix_item_t;

    // ------------------------------------------------------------------
    // scoreboard: own copy of the font sheet and the sheet registers,
    // expands every accepted draw into its 48 pixel writes
    // ------------------------------------------------------------------
    class blit_scoreboard;
        logic [COLOUR_W-1:0]   sheet_copy [SHEET_MAX_W_DEF * SHEET_MAX_H_DEF];
        logic [CFG_DATA_W-1:0] width_reg;
        logic [CFG_DATA_W-1:0] height_reg;
        pix_item_t             pending_pix [$];
        int                    errors;
        int                    loads;
        int                    glyphs;
        int                    pixels;
        int                    blanked;
        int                    reg_writes;

        function new();
            width_reg  = SHEET_WIDTH_RST;
            height_reg = SHEET_HEIGHT_RST;
            errors     = 0;
            loads      = 0;
            glyphs     = 0;
            pixels     = 0;
            blanked    = 0;
            reg_writes = 0;
            foreach (sheet_copy[i])
                sheet_copy[i] = '0;
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        function int pending();
            return pending_pix.size();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            reg_writes++;
            if (idx == REG_SHEET_WIDTH)
                width_reg = data;
            else if (idx == REG_SHEET_HEIGHT)
                height_reg = data;
        endfunction

        function void note_cmd(cmd_item_t c);
            int unsigned src_x0;
            int unsigned src_y0;
            int unsigned dst_x0;
            int unsigned w_lim;
            int unsigned h_lim;
            int unsigned sx;
            int unsigned sy;
            int unsigned k;
            int unsigned a;
            int unsigned b;
            pix_item_t   p;
            if (c.op == OP_LOAD) begin
                sheet_copy[32'(c.load_y) * SHEET_MAX_W_DEF + 32'(c.load_x)] = c.load_colour;
                loads++;
                return;
            end
            src_x0 = (32'(c.char_code) % CELLS_PER_ROW) * GLYPH_W_DEF;
            src_y0 = (32'(c.char_code) / CELLS_PER_ROW) * GLYPH_H_DEF;
            dst_x0 = 32'(c.origin_x) + 32'(c.char_pos) * GLYPH_W_DEF;
            w_lim  = (32'(width_reg) < SHEET_MAX_W_DEF) ? 32'(width_reg) : SHEET_MAX_W_DEF;
            h_lim  = (32'(height_reg) < SHEET_MAX_H_DEF) ? 32'(height_reg) : SHEET_MAX_H_DEF;
            k = 0;
            for (b = 0; b < GLYPH_H_DEF; b++) begin
                for (a = 0; a < GLYPH_W_DEF; a++) begin
                    sx = src_x0 + a;
                    sy = src_y0 + b;
                    p.write_enable = (sx < w_lim) && (sy < h_lim);
                    p.colour       = p.write_enable ? sheet_copy[sy * SHEET_MAX_W_DEF + sx] : '0;
                    p.screen_x     = SCREEN_W'(dst_x0 + a);
                    p.screen_y     = SCREEN_W'(32'(c.origin_y) + b);
                    p.last_pixel   = (k + 1 == GLYPH_PIXELS);
                    pending_pix.push_back(p);
                    k++;
                end
            end
            glyphs++;
        endfunction

        task check_pix(pix_item_t got);
            pix_item_t want;
            if (pending_pix.size() == 0) begin
                report($sformatf("pixel x=%0d y=%0d arrived with no glyph pending",
                                 got.screen_x, got.screen_y));
                return;
            end
            want = pending_pix.pop_front();
            pixels++;
            if (!want.write_enable)
                blanked++;
            if (got.screen_x !== want.screen_x || got.screen_y !== want.screen_y ||
                got.colour !== want.colour || got.write_enable !== want.write_enable ||
                got.last_pixel !== want.last_pixel)
                report($sformatf(
                    "pixel %0d got x=%0d y=%0d col=%h we=%b last=%b want x=%0d y=%0d col=%h we=%b last=%b",
                    pixels, got.screen_x, got.screen_y, got.colour, got.write_enable,
                    got.last_pixel, want.screen_x, want.screen_y, want.colour,
                    want.write_enable, want.last_pixel));
        endtask
    endclass

    // ------------------------------------------------------------------
    // clock, reset, channels and the block
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    fgb_cmd_if cmd_ch ();
    fgb_pix_if pix_ch ();
    fgb_cfg_if cfg_ch ();

    font_glyph_blitter DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .pix   (pix_ch),
        .cfg   (cfg_ch)
    );

    always #HALF_PERIOD clk = ~clk;

    blit_scoreboard sb = new();

    // which sheet pixels have been loaded, so a draw never reads an unwritten entry
    bit sheet_loaded [SHEET_MAX_H_DEF][SHEET_MAX_W_DEF];

    // sheet registers as the sender last wrote them
    logic [CFG_DATA_W-1:0] cur_width  = SHEET_WIDTH_RST;
    logic [CFG_DATA_W-1:0] cur_height = SHEET_HEIGHT_RST;

    // codes that come back again and again, so their cells are loaded once
    logic [CODE_W-1:0] code_pool [POOL_SIZE];

    bit steady;         // no idling on either side
    bit burst;          // sender offers items back to back
    int hold_requests;  // raised by the sender, one long receiver hold-off each
    int holds_served;
    int cycles;

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    always @(posedge clk) begin : watchdog
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("run stopped by watchdog after %0d cycles, %0d pixels still due",
                     cycles, sb.pending());
            $display("tb_font_glyph_blitter NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // monitors: everything is sampled at the accepting edge
    // ------------------------------------------------------------------
    always @(posedge clk) begin : cmd_monitor
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
            sb.note_cmd({cmd_ch.op, cmd_ch.load_x, cmd_ch.load_y, cmd_ch.load_colour,
                         cmd_ch.char_code, cmd_ch.char_pos, cmd_ch.origin_x,
                         cmd_ch.origin_y});
    end

    always @(posedge clk) begin : pix_monitor
        if (rst_n && pix_ch.valid && pix_ch.ready)
            sb.check_pix({pix_ch.screen_x, pix_ch.screen_y, pix_ch.colour,
                          pix_ch.write_enable, pix_ch.last_pixel});
    end

    always @(posedge clk) begin : cfg_monitor
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
            sb.set_reg(cfg_ch.index, cfg_ch.data);
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------
    // receiver: random ready, a long hold-off on request
    // ------------------------------------------------------------------
    initial begin : pix_receiver
        int run_len;
        int gap;
        pix_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (holds_served < hold_requests) begin
                // hold off long enough for the block to back up into cmd
                pix_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_served++;
            end
            else if (steady) begin
                pix_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else begin
                run_len = $urandom_range(1, 8);
                pix_ch.ready <= 1'b1;
                repeat (run_len) @(posedge clk);
                gap = pick_gap();
                if (gap > 0) begin
                    pix_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sender tasks
    // ------------------------------------------------------------------

    // every field random, the op as asked
    function automatic cmd_item_t random_cmd(logic [OP_W-1:0] op);
        cmd_item_t c;
        c.op          = op;
        c.load_x      = LOAD_X_W'($urandom());
        c.load_y      = LOAD_Y_W'($urandom());
        c.load_colour = COLOUR_W'($urandom());
        c.char_code   = CODE_W'($urandom());
        c.char_pos    = POS_W'($urandom());
        c.origin_x    = ORIGIN_W'($urandom());
        c.origin_y    = ORIGIN_W'($urandom());
        return c;
    endfunction

    // offer one item, wait for it to be taken, then maybe leave a gap
    task automatic put_cmd(cmd_item_t c);
        int gap;
        cmd_ch.valid       <= 1'b1;
        cmd_ch.op          <= c.op;
        cmd_ch.load_x      <= c.load_x;
        cmd_ch.load_y      <= c.load_y;
        cmd_ch.load_colour <= c.load_colour;
        cmd_ch.char_code   <= c.char_code;
        cmd_ch.char_pos    <= c.char_pos;
        cmd_ch.origin_x    <= c.origin_x;
        cmd_ch.origin_y    <= c.origin_y;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        if (c.op == OP_LOAD)
            sheet_loaded[c.load_y][c.load_x] = 1'b1;
        gap = (steady || burst) ? 0 : pick_gap();
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic load_pixel(input int unsigned x, input int unsigned y,
                              input logic [COLOUR_W-1:0] col);
        cmd_item_t c;
        c             = random_cmd(OP_LOAD);
        c.load_x      = LOAD_X_W'(x);
        c.load_y      = LOAD_Y_W'(y);
        c.load_colour = col;
        put_cmd(c);
    endtask

    // load, with random colours, every pixel of the cell that the
    // current sheet size lets a draw read and that is still unwritten
    task automatic fill_cell(logic [CODE_W-1:0] code);
        int unsigned x0;
        int unsigned y0;
        int unsigned w_lim;
        int unsigned h_lim;
        int unsigned x;
        int unsigned y;
        x0    = (32'(code) % CELLS_PER_ROW) * GLYPH_W_DEF;
        y0    = (32'(code) / CELLS_PER_ROW) * GLYPH_H_DEF;
        w_lim = (32'(cur_width) < SHEET_MAX_W_DEF) ? 32'(cur_width) : SHEET_MAX_W_DEF;
        h_lim = (32'(cur_height) < SHEET_MAX_H_DEF) ? 32'(cur_height) : SHEET_MAX_H_DEF;
        for (y = y0; y < y0 + GLYPH_H_DEF; y++)
            for (x = x0; x < x0 + GLYPH_W_DEF; x++)
                if (x < w_lim && y < h_lim && !sheet_loaded[y][x])
                    load_pixel(x, y, COLOUR_W'($urandom()));
    endtask

    task automatic draw_char(input logic [CODE_W-1:0] code, input logic [POS_W-1:0] pos,
                             input logic [ORIGIN_W-1:0] ox, input logic [ORIGIN_W-1:0] oy);
        cmd_item_t c;
        fill_cell(code);
        c           = random_cmd(OP_DRAW);
        c.char_code = code;
        c.char_pos  = pos;
        c.origin_x  = ox;
        c.origin_y  = oy;
        put_cmd(c);
    endtask

    // pooled codes, edges of position and origin now and then
    task automatic random_draw();
        logic [CODE_W-1:0]   code;
        logic [POS_W-1:0]    pos;
        logic [ORIGIN_W-1:0] ox;
        logic [ORIGIN_W-1:0] oy;
        int                  r;
        code = code_pool[$urandom_range(0, POOL_SIZE - 1)];
        r   = $urandom_range(0, 9);
        pos = (r == 0) ? '0 : (r == 1) ? '1 : POS_W'($urandom());
        r   = $urandom_range(0, 9);
        ox  = (r == 0) ? '0 : (r == 1) ? '1 : ORIGIN_W'($urandom());
        r   = $urandom_range(0, 9);
        oy  = (r == 0) ? '0 : (r == 1) ? '1 : ORIGIN_W'($urandom());
        draw_char(code, pos, ox, oy);
    endtask

    // stop offering and wait until every pixel due has come out
    task automatic wait_drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == REG_SHEET_WIDTH)
            cur_width = data;
        else if (idx == REG_SHEET_HEIGHT)
            cur_height = data;
    endtask

    // new sheet size, only ever with the block idle
    task automatic set_sheet(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        wait_drain();
        write_reg(REG_SHEET_WIDTH, w);
        write_reg(REG_SHEET_HEIGHT, h);
        cfg_ch.valid <= 1'b0;
    endtask

    // a third of the items are stray loads, the rest draws of loaded cells,
    // sometimes after the sender has let everything drain
    task automatic random_phase(int n_ops);
        int r;
        repeat (n_ops) begin
            r = $urandom_range(0, 99);
            if (r < 35)
                put_cmd(random_cmd(OP_LOAD));
            else begin
                if (r < 40)
                    wait_drain();
                random_draw();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int i;
        rst_n              <= 1'b0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.op          <= OP_LOAD;
        cmd_ch.load_x      <= '0;
        cmd_ch.load_y      <= '0;
        cmd_ch.load_colour <= '0;
        cmd_ch.char_code   <= '0;
        cmd_ch.char_pos    <= '0;
        cmd_ch.origin_x    <= '0;
        cmd_ch.origin_y    <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= REG_SHEET_WIDTH;
        cfg_ch.data        <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first cell, last cell of the first row and last cell of the sheet
        code_pool[0] = 8'h00;
        code_pool[1] = 8'h0F;
        code_pool[2] = 8'hFF;

        // directed: reset sheet size first, corner loads of the store
        load_pixel(0, 0, 8'h00);
        load_pixel(SHEET_MAX_W_DEF - 1, SHEET_MAX_H_DEF - 1, 8'hFF);
        load_pixel(SHEET_MAX_W_DEF - 1, 0, 8'hA5);
        load_pixel(0, SHEET_MAX_H_DEF - 1, 8'h5A);

        // first and last cell, smallest and largest position and origin
        draw_char(8'h00, 6'd0, 10'd0, 10'd0);
        draw_char(8'hFF, 6'd63, 10'd1023, 10'd1023);
        draw_char(8'h0F, 6'd1, 10'd1023, 10'd0);

        // zero width blanks every pixel, oversized height is clamped
        set_sheet(8'd0, 8'd255);
        draw_char(8'hA5, 6'd42, 10'd513, 10'd255);

        // zero height, oversized width
        set_sheet(8'd255, 8'd0);
        draw_char(8'h5A, 6'd21, 10'd256, 10'd768);

        // edges cutting through the last cell column and the last cell row
        set_sheet(8'd93, 8'd124);
        draw_char(8'hFF, 6'd5, 10'd100, 10'd200);
        draw_char(8'h0F, 6'd0, 10'd7, 10'd9);
        draw_char(8'h00, 6'd63, 10'd0, 10'd1023);

        // one pixel sheet
        set_sheet(8'd1, 8'd1);
        draw_char(8'h00, 6'd10, 10'd0, 10'd0);

        // indexes past the two registers change nothing
        wait_drain();
        write_reg(REG_SPARE0, 8'h00);
        write_reg(REG_SPARE1, 8'hFF);
        cfg_ch.valid <= 1'b0;

        // largest sheet that counts
        set_sheet(8'd128, 8'd128);
        draw_char(8'hFF, 6'd32, 10'd512, 10'd512);

        // random: full sheet with no idling anywhere
        steady = 1'b1;
        random_phase(10);
        wait_drain();
        steady = 1'b0;

        // random sizes inside the legal range
        set_sheet(CFG_DATA_W'($urandom_range(1, 128)), CFG_DATA_W'($urandom_range(1, 128)));
        random_phase(12);

        // receiver holds off while the sender keeps pushing draws
        set_sheet(8'd255, 8'd200);
        for (i = 0; i < POOL_SIZE; i++)
            fill_cell(code_pool[i]);
        burst = 1'b1;
        hold_requests++;
        for (i = 0; i < 6; i++)
            draw_char(code_pool[i % POOL_SIZE], POS_W'($urandom()), ORIGIN_W'($urandom()),
                      ORIGIN_W'($urandom()));
        burst = 1'b0;
        random_phase(8);

        // any register value at all
        set_sheet(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()));
        random_phase(10);

        // back to the reset size
        set_sheet(SHEET_WIDTH_RST, SHEET_HEIGHT_RST);
        random_phase(10);

        set_sheet(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()));
        random_phase(10);

        // let the last glyph out, then watch for anything extra
        wait_drain();
        repeat (4 * SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d loads, %0d glyphs, %0d pixels (%0d blanked), %0d register writes",
                 sb.loads, sb.glyphs, sb.pixels, sb.blanked, sb.reg_writes);
        $display("sheet sizes zero, one, cut-through, full and oversized; %0d hold-offs, %0d mismatches",
                 holds_served, sb.errors);
        if (sb.errors == 0)
            $display("tb_font_glyph_blitter OK");
        else
            $display("tb_font_glyph_blitter NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
